>>> sv/acps_pkg.sv
// ---------------------------------------------------------------------------
// acps_pkg: shared types and constants of the audio cue priority scheduler
// Holds the payload structs, result codes, register indexes and state enum.
// ---------------------------------------------------------------------------
`default_nettype none
package acps_pkg;

   localparam int QUEUE_DEPTH   = 16;
   localparam int MAX_PER_FRAME = 4;
   localparam int NUM_IDS       = 8;
   localparam int PRIORITY_BITS = 2;

   localparam int QIDX_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
   localparam int SLOT_W = $clog2(NUM_IDS);
   localparam int NPF_W  = $clog2(MAX_PER_FRAME + 1);
   localparam int ENTRY_W = 3 + PRIORITY_BITS + 32;

   localparam logic [2:0] KIND_QUEUED       = 3'd0;
   localparam logic [2:0] KIND_REF_COOLDOWN = 3'd1;
   localparam logic [2:0] KIND_REF_FULL     = 3'd2;
   localparam logic [2:0] KIND_PLAYED       = 3'd3;
   localparam logic [2:0] KIND_NONE         = 3'd4;

   localparam logic OP_ENQUEUE = 1'b0;
   localparam logic OP_TICK    = 1'b1;

   localparam logic [2:0] REG_CD_0_3   = 3'd0;
   localparam logic [2:0] REG_CD_4_6   = 3'd1;
   localparam logic [2:0] REG_CD_DEF   = 3'd2;
   localparam logic [2:0] REG_STALE    = 3'd3;
   localparam logic [2:0] REG_TRIM     = 3'd4;
   localparam logic [2:0] REG_KEEP_MIN = 3'd5;

   typedef struct packed {
      logic        opcode;
      logic [2:0]  sample_id;
      logic [1:0]  priority_req;
      logic [31:0] current_time;
   } req_type;

   typedef struct packed {
      logic [2:0] result_kind;
      logic [2:0] played_id;
      logic [4:0] queue_count;
      logic       last;
   } rsp_type;

   typedef struct packed {
      logic [2:0]               id;
      logic [PRIORITY_BITS-1:0] pri;
      logic [31:0]              ts;
   } entry_type;

   typedef struct packed {
      logic [63:0] cd_0_3;
      logic [47:0] cd_4_6;
      logic [15:0] cd_def;
      logic [15:0] stale;
      logic [4:0]  trim;
      logic [1:0]  keep_min;
   } cfg_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_STALE_RD, ST_STALE_WR, ST_ENQ_CHECK, ST_EVICT_RD, ST_EVICT_MV,
      ST_APPEND, ST_SEL_RD, ST_SEL_CMP, ST_SEL_MV, ST_TRIM_RD, ST_TRIM_WR,
      ST_TAIL
   } state_type;

endpackage
`default_nettype wire

>>> sv/audio_cue_priority_scheduler_top.sv
// ---------------------------------------------------------------------------
// audio_cue_priority_scheduler_top: cue request queue with cooldowns
// Sequencer over a queue RAM; one compare unit walks the entries in turn.
// ---------------------------------------------------------------------------
// channel | ports                       | transfer
// req     | start, busy, req_payload    | start high while busy low
// rsp     | rsp_strobe, rsp_payload     | every cycle rsp_strobe is high
// csr     | csr_valid/ready, index/data | csr_valid and csr_ready high
//
// Every pass handles each entry in a read step (issue the RAM read) and a
// compare or write step, then closes. The stale pass runs first; an enqueue
// then checks the cooldown and appends, after searching for a victim when
// the queue is full. A tick repeats its picks (scan, emit, shift), then runs
// an optional trim pass and the tail.
// busy is high throughout; each result is registered and reaches the ports
// in the cycle after it is formed. Synchronous reset clears the count and
// play records; the queue RAM and play times need no clearing. Results
// cannot be stalled by the receiver.
// ---------------------------------------------------------------------------
`default_nettype none
module audio_cue_priority_scheduler_top (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   output logic                     busy,
   input  wire acps_pkg::req_type   req_payload,
   output logic                     rsp_strobe,
   output acps_pkg::rsp_type        rsp_payload,
   input  wire logic                csr_valid,
   output logic                     csr_ready,
   input  wire logic [2:0]          csr_index,
   input  wire logic [63:0]         csr_data
);
   import acps_pkg::*;

   cfg_type cfg;

   acps_csr u_csr (
      .clock(clock), .reset(reset), .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data), .cfg(cfg)
   );

   // state and item registers
   state_type state_ff, state_in;
   req_type   req_ff, req_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;     // entries in queue
   logic [CNT_W-1:0]  rd_ff, rd_in;       // read pointer of a pass
   logic [CNT_W-1:0]  wr_ff, wr_in;       // write pointer of a compacting pass
   logic [QIDX_W-1:0] best_ff, best_in;
   entry_type         bent_ff, bent_in;
   logic              found_ff, found_in;
   logic [NPF_W-1:0]  nplay_ff, nplay_in;
   logic [2:0]        kind_ff, kind_in;
   logic [NUM_IDS-1:0] played_ff, played_in;
   logic [31:0]       lpt_ff [NUM_IDS];
   logic              lpt_we;
   logic [SLOT_W-1:0] lpt_slot;

   // RAM ports
   logic              ram_we;
   logic [QIDX_W-1:0] ram_wa, ram_ra;
   entry_type         ram_wd, ram_rd;

   acps_ram #(.WIDTH(ENTRY_W), .DEPTH(QUEUE_DEPTH)) u_queue (
      .clock(clock), .wr_en(ram_we), .wr_addr(ram_wa), .wr_data(ram_wd),
      .rd_addr(ram_ra), .rd_data(ram_rd)
   );

   logic [31:0] age;
   logic [15:0] cd;
   logic [SLOT_W-1:0] slot;
   logic        better;
   logic        rsp_stb_c;
   rsp_type     rsp_c;

   assign age  = req_ff.current_time - ram_rd.ts;
   assign slot = req_ff.sample_id[SLOT_W-1:0];
   assign busy = (state_ff != ST_IDLE);

   always_comb begin
      unique case (req_ff.sample_id)
         3'd0: cd = cfg.cd_0_3[15:0];
         3'd1: cd = cfg.cd_0_3[31:16];
         3'd2: cd = cfg.cd_0_3[47:32];
         3'd3: cd = cfg.cd_0_3[63:48];
         3'd4: cd = cfg.cd_4_6[15:0];
         3'd5: cd = cfg.cd_4_6[31:16];
         3'd6: cd = cfg.cd_4_6[47:32];
         default: cd = cfg.cd_def;
      endcase
   end

   // compare unit of the selection pass: candidate beats current best
   always_comb begin
      logic [31:0] bage;
      bage   = req_ff.current_time - bent_ff.ts;
      better = !found_ff || (ram_rd.pri > bent_ff.pri) ||
               ((ram_rd.pri == bent_ff.pri) && (age > bage));
   end

   always_comb begin
      state_in  = state_ff;
      req_in    = req_ff;
      cnt_in    = cnt_ff;
      rd_in     = rd_ff;
      wr_in     = wr_ff;
      best_in   = best_ff;
      bent_in   = bent_ff;
      found_in  = found_ff;
      nplay_in  = nplay_ff;
      kind_in   = kind_ff;
      played_in = played_ff;
      ram_we    = 1'b0;
      ram_wa    = wr_ff[QIDX_W-1:0];
      ram_wd    = ram_rd;
      ram_ra    = rd_ff[QIDX_W-1:0];
      lpt_we    = 1'b0;
      lpt_slot  = bent_ff.id[SLOT_W-1:0];
      rsp_stb_c = 1'b0;
      rsp_c     = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               req_in   = req_payload;
               rd_in    = '0;
               wr_in    = '0;
               nplay_in = '0;
               state_in = ST_STALE_RD;
            end
         end
         // issue read of entry rd
         ST_STALE_RD: begin
            if (rd_ff == cnt_ff) begin
               cnt_in   = wr_ff;
               state_in = (req_ff.opcode == OP_ENQUEUE) ? ST_ENQ_CHECK : ST_SEL_RD;
               rd_in    = '0;
               found_in = 1'b0;
            end else begin
               rd_in    = rd_ff + 1'b1;
               state_in = ST_STALE_WR;
            end
         end
         // keep fresh entries, compact down
         ST_STALE_WR: begin
            if (age <= {16'd0, cfg.stale}) begin
               ram_we = 1'b1;
               wr_in  = wr_ff + 1'b1;
            end
            ram_ra   = rd_ff[QIDX_W-1:0];
            state_in = ST_STALE_RD;
         end
         ST_ENQ_CHECK: begin
            rd_in = '0;
            if (played_ff[slot] &&
                ((req_ff.current_time - lpt_ff[slot]) < {16'd0, cd})) begin
               kind_in  = KIND_REF_COOLDOWN;
               state_in = ST_TAIL;
            end else if (cnt_ff == CNT_W'(QUEUE_DEPTH)) begin
               state_in = ST_EVICT_RD;
               found_in = 1'b0;
               wr_in    = '0;
            end else begin
               state_in = ST_APPEND;
            end
         end
         // find first lower-priority entry, then shift the rest down
         ST_EVICT_RD: begin
            if (rd_ff == cnt_ff) begin
               if (!found_ff) begin
                  kind_in  = KIND_REF_FULL;
                  state_in = ST_TAIL;
               end else begin
                  cnt_in   = cnt_ff - 1'b1;
                  state_in = ST_APPEND;
               end
            end else begin
               rd_in    = rd_ff + 1'b1;
               state_in = ST_EVICT_MV;
            end
         end
         ST_EVICT_MV: begin
            if (found_ff) begin
               ram_we = 1'b1;
               wr_in  = wr_ff + 1'b1;
            end else if (ram_rd.pri < req_ff.priority_req[PRIORITY_BITS-1:0]) begin
               found_in = 1'b1;
            end else begin
               wr_in = wr_ff + 1'b1;
            end
            state_in = ST_EVICT_RD;
         end
         ST_APPEND: begin
            ram_we    = 1'b1;
            ram_wa    = cnt_ff[QIDX_W-1:0];
            ram_wd.id = req_ff.sample_id;
            ram_wd.pri = req_ff.priority_req[PRIORITY_BITS-1:0];
            ram_wd.ts = req_ff.current_time;
            cnt_in    = cnt_ff + 1'b1;
            kind_in   = KIND_QUEUED;
            state_in  = ST_TAIL;
         end
         // selection pass: scan all entries through the compare unit
         ST_SEL_RD: begin
            if (cnt_ff == '0 || nplay_ff == NPF_W'(MAX_PER_FRAME)) begin
               rd_in    = '0;
               wr_in    = '0;
               state_in = (cnt_ff > cfg.trim) ? ST_TRIM_RD : ST_TAIL;
               kind_in  = KIND_NONE;
            end else if (rd_ff == cnt_ff) begin
               // winner known: record play, emit, shift tail down
               lpt_we    = 1'b1;
               played_in[bent_ff.id[SLOT_W-1:0]] = 1'b1;
               rsp_stb_c = 1'b1;
               rsp_c.result_kind = KIND_PLAYED;
               rsp_c.played_id   = bent_ff.id;
               rsp_c.queue_count = 5'(cnt_ff - 1'b1);
               rsp_c.last = 1'b0;
               nplay_in = nplay_ff + 1'b1;
               rd_in    = {1'b0, best_ff} + 1'b1;
               wr_in    = {1'b0, best_ff};
               state_in = ST_SEL_MV;
            end else begin
               rd_in    = rd_ff + 1'b1;
               state_in = ST_SEL_CMP;
            end
         end
         ST_SEL_CMP: begin
            if (better) begin
               found_in = 1'b1;
               best_in  = QIDX_W'(rd_ff - 1'b1);
               bent_in  = ram_rd;
            end
            state_in = ST_SEL_RD;
         end
         // shift entries above the winner down by one; each read is issued ahead of its write
         ST_SEL_MV: begin
            if (rd_ff == cnt_ff) begin
               cnt_in   = cnt_ff - 1'b1;
               rd_in    = '0;
               found_in = 1'b0;
               state_in = ST_SEL_RD;
            end else begin
               rd_in    = rd_ff + 1'b1;
               state_in = ST_TRIM_WR;
               kind_in  = KIND_PLAYED;
            end
         end
         ST_TRIM_RD: begin
            if (rd_ff == cnt_ff) begin
               cnt_in   = wr_ff;
               state_in = ST_TAIL;
            end else begin
               rd_in    = rd_ff + 1'b1;
               state_in = ST_TRIM_WR;
               kind_in  = KIND_NONE;
            end
         end
         // shared write step of trim and winner shift
         ST_TRIM_WR: begin
            if (kind_ff == KIND_PLAYED || ram_rd.pri >= cfg.keep_min[PRIORITY_BITS-1:0]) begin
               ram_we = 1'b1;
               wr_in  = wr_ff + 1'b1;
            end
            state_in = (kind_ff == KIND_PLAYED) ? ST_SEL_MV : ST_TRIM_RD;
         end
         ST_TAIL: begin
            rsp_stb_c = 1'b1;
            rsp_c.queue_count = 5'(cnt_ff);
            rsp_c.last = 1'b1;
            if (req_ff.opcode == OP_TICK && nplay_ff != '0) begin
               // final played result was held back to carry post-trim count
               rsp_c.result_kind = KIND_PLAYED;
               rsp_c.played_id   = bent_ff.id;
            end else begin
               rsp_c.result_kind = kind_ff;
            end
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // the played result of the final pick is deferred to the tail
   logic final_pick;
   assign final_pick = (state_ff == ST_SEL_RD) && (rd_ff == cnt_ff) &&
                       (cnt_ff != '0) && (nplay_ff != NPF_W'(MAX_PER_FRAME)) &&
                       ((cnt_ff == CNT_W'(1)) || (nplay_ff == NPF_W'(MAX_PER_FRAME - 1)));

   logic       rsp_strobe_q;
   rsp_type    rsp_hold;
   assign rsp_strobe_q = rsp_stb_c && !final_pick;
   assign rsp_hold     = rsp_c;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         cnt_ff    <= '0;
         played_ff <= '0;
         nplay_ff  <= '0;
         found_ff  <= 1'b0;
      end else begin
         state_ff  <= state_in;
         cnt_ff    <= cnt_in;
         played_ff <= played_in;
         nplay_ff  <= nplay_in;
         found_ff  <= found_in;
      end
      req_ff  <= req_in;
      rd_ff   <= rd_in;
      wr_ff   <= wr_in;
      best_ff <= best_in;
      bent_ff <= bent_in;
      kind_ff <= kind_in;
      if (lpt_we) begin
         lpt_ff[lpt_slot] <= req_ff.current_time;
      end
   end

   // registered result port
   logic    out_stb_ff;
   rsp_type out_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         out_stb_ff <= 1'b0;
      end else begin
         out_stb_ff <= rsp_strobe_q;
      end
      out_ff <= rsp_hold;
   end

   assign rsp_strobe  = out_stb_ff;
   assign rsp_payload = out_ff;

`ifndef SYNTHESIS
   a_busy_no_out: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |=> !out_stb_ff) else $error("result without work");
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(QUEUE_DEPTH)) else $error("count overflow");
   a_tail_last: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_TAIL) |=> (out_stb_ff && out_ff.last)) else $error("tail lost");
`endif
endmodule
`default_nettype wire

>>> sv/acps_ram.sv
// ---------------------------------------------------------------------------
// acps_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none
module acps_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule
`default_nettype wire

>>> sv/acps_csr.sv
// ---------------------------------------------------------------------------
// acps_csr: configuration register file
// Takes register writes and presents the settings as one struct.
// ---------------------------------------------------------------------------
`default_nettype none
module acps_csr (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              csr_valid,
   output logic                   csr_ready,
   input  wire logic [2:0]        csr_index,
   input  wire logic [63:0]       csr_data,
   output acps_pkg::cfg_type      cfg
);
   import acps_pkg::*;

   cfg_type cfg_ff;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.cd_0_3   <= 64'd42221890764800100;
         cfg_ff.cd_4_6   <= 48'd429503283350;
         cfg_ff.cd_def   <= 16'd50;
         cfg_ff.stale    <= 16'd1000;
         cfg_ff.trim     <= 5'd8;
         cfg_ff.keep_min <= 2'd1;
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_CD_0_3:   cfg_ff.cd_0_3   <= csr_data;
            REG_CD_4_6:   cfg_ff.cd_4_6   <= csr_data[47:0];
            REG_CD_DEF:   cfg_ff.cd_def   <= csr_data[15:0];
            REG_STALE:    cfg_ff.stale    <= csr_data[15:0];
            REG_TRIM:     cfg_ff.trim     <= csr_data[4:0];
            REG_KEEP_MIN: cfg_ff.keep_min <= csr_data[1:0];
            default: ;
         endcase
      end
   end
endmodule
`default_nettype wire
